// ===== design/vlc_pkg.sv =====
`timescale 1ns / 1ps

package vlc_pkg;

    localparam int unsigned PWM_W    = 12;
    localparam int unsigned PWM_FULL = 4095;
    // Every level is held at twelve bits, so full scale is stored masked.
    localparam logic [PWM_W-1:0] PWM_FULL_LVL = PWM_FULL[PWM_W-1:0];

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_PARK_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_BASE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BEAM     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 3'd4;

    localparam logic [7:0]  PARK_BASE_RST    = 8'd32;
    localparam logic [7:0]  TAIL_BASE_RST    = 8'd32;
    localparam logic [11:0] LOW_BEAM_RST     = 12'd32;
    localparam logic [7:0]  REFRESH_MS_RST   = 8'd50;
    localparam logic [10:0] BLINK_PERIOD_RST = 11'd1200;

    localparam logic [11:0]        RAMP_TURN    = 12'd600;
    localparam logic [7:0]         RAMP_TOP     = 8'd255;
    // 255 + 2 * 600: falling edge of the ramp is RAMP_FALL0 - 2 * phase
    localparam logic signed [13:0] RAMP_FALL0   = 14'sd1455;
    localparam logic [11:0]        PHASE_MAX    = 12'd4095;
    localparam logic [7:0]         COUNT_MAX    = 8'd255;

    localparam logic [1:0] LEVEL_OFF  = 2'd0;
    localparam logic [1:0] LEVEL_PARK = 2'd1;
    localparam logic [1:0] LEVEL_LOW  = 2'd2;
    localparam logic [1:0] LEVEL_FULL = 2'd3;

    localparam logic MODE_COMMAND = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] command;
    } t_in;

    typedef struct packed {
        logic [PWM_W-1:0] left_front;
        logic [PWM_W-1:0] right_front;
        logic [PWM_W-1:0] left_rear;
        logic [PWM_W-1:0] right_rear;
        logic [PWM_W-1:0] headlight;
        logic [PWM_W-1:0] reverse_light;
        logic [5:0]       status;
    } t_out;

endpackage

// ===== design/vehicle_light_controller_top.sv =====
`timescale 1ns / 1ps

// Vehicle light controller: each input transfer is either a command byte
// (mode 0) or a one-millisecond tick (mode 1), and each produces exactly one
// result transfer carrying all six PWM levels and a status word. The state
// and the result register are updated at the edge that accepts the item, so
// one item is taken every cycle and the result appears in the next cycle; the
// only limit is the single result register, which holds a result until the
// far side takes it (input stall follows output stall only while a result
// is waiting). The configuration channel is always ready and should be used
// only while no result is outstanding.
module vehicle_light_controller_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  vlc_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output vlc_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [vlc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vlc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import vlc_pkg::*;

    // Configuration registers
    logic [7:0]  r_park_base;
    logic [7:0]  r_tail_base;
    logic [11:0] r_low_beam;
    logic [7:0]  r_refresh_ms;
    logic [10:0] r_blink_period;

    // Light state
    logic        r_left, r_right, r_any_memo, r_brake, r_reverse;
    logic [1:0]  r_level;
    logic [11:0] r_phase;
    logic [7:0]  r_refresh_count;
    logic [PWM_W-1:0] r_lf, r_rf, r_lr, r_rr, r_hl, r_rv;

    logic        n_left, n_right, n_any_memo, n_brake, n_reverse;
    logic [1:0]  n_level;
    logic [11:0] n_phase;
    logic [7:0]  n_refresh_count;
    logic [PWM_W-1:0] n_lf, n_rf, n_lr, n_rr, n_hl, n_rv;
    logic        n_refresh;

    logic        r_out_valid;
    t_out        r_out;

    logic        in_accept;
    logic [7:0]  front_base, rear_base;
    logic [7:0]  n_front_base, n_rear_base;
    logic [7:0]  ramp_front, ramp_rear;

    // Ramp over the blink phase: rise at 2.5 per ms to full, fall at 2 per ms
    // after the turn, never below the base.
    function automatic logic [7:0] ramp(input logic [11:0] p, input logic [7:0] base);
        logic [14:0]        x5;
        logic signed [13:0] dn;
        logic [7:0]         v;
        logic               under;
        x5 = {3'b000, p} + {1'b0, p, 2'b00};
        dn = RAMP_FALL0 - $signed({1'b0, p, 1'b0});
        if (p < RAMP_TURN) begin
            v     = (x5[14:1] > {6'd0, RAMP_TOP}) ? RAMP_TOP : x5[8:1];
            under = v < base;
        end else begin
            v     = dn[7:0];
            under = dn < $signed({6'd0, base});
        end
        return under ? base : v;
    endfunction

    // Hold a waiting result; take a new item whenever the register frees.
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign front_base = (r_level != LEVEL_OFF) ? r_park_base : 8'd0;
    assign rear_base  = (r_level != LEVEL_OFF) ? r_tail_base : 8'd0;

    // Next state for one item
    always_comb begin
        n_left          = r_left;
        n_right         = r_right;
        n_any_memo      = r_any_memo;
        n_brake         = r_brake;
        n_reverse       = r_reverse;
        n_level         = r_level;
        n_phase         = r_phase;
        n_refresh_count = r_refresh_count;
        n_lf            = r_lf;
        n_rf            = r_rf;
        n_lr            = r_lr;
        n_rr            = r_rr;
        n_hl            = r_hl;
        n_rv            = r_rv;
        n_refresh       = 1'b0;
        n_front_base    = front_base;
        n_rear_base     = rear_base;
        ramp_front      = '0;
        ramp_rear       = '0;
        if (i_in_data.mode == MODE_TICK) begin
            // Advance both counters, saturating
            if (r_refresh_count < COUNT_MAX) begin
                n_refresh_count = r_refresh_count + 8'd1;
            end
            if (r_phase < PHASE_MAX) begin
                n_phase = r_phase + 12'd1;
            end
            n_refresh = n_refresh_count > r_refresh_ms;
            if (n_refresh) begin
                if (n_phase > {1'b0, r_blink_period}) begin
                    n_phase = 12'd0;
                end
                ramp_front = ramp(n_phase, front_base);
                ramp_rear  = ramp(n_phase, rear_base);
                if (r_left) begin
                    n_lf = {4'd0, ramp_front};
                    n_lr = {4'd0, ramp_rear};
                end
                if (r_right) begin
                    n_rf = {4'd0, ramp_front};
                    n_rr = {4'd0, ramp_rear};
                end
                n_refresh_count = 8'd0;
            end
        end else begin
            // Dimmer first, then brighter
            if (i_in_data.command[2] && n_level != LEVEL_OFF) begin
                n_level = n_level - 2'd1;
            end
            if (i_in_data.command[3] && n_level != LEVEL_FULL) begin
                n_level = n_level + 2'd1;
            end
            n_front_base = (n_level != LEVEL_OFF) ? r_park_base : 8'd0;
            n_rear_base  = (n_level != LEVEL_OFF) ? r_tail_base : 8'd0;
            unique case (n_level)
                LEVEL_PARK: n_hl = '0;
                LEVEL_LOW:  n_hl = r_low_beam;
                LEVEL_FULL: n_hl = PWM_FULL_LVL;
                default:    n_hl = r_hl;
            endcase
            n_lf = {4'd0, n_front_base};
            n_rf = {4'd0, n_front_base};
            n_left  = r_left ^ i_in_data.command[0];
            n_right = r_right ^ i_in_data.command[1];
            // Restart the blink phase when an indicator first comes on
            if (!r_any_memo && (n_left || n_right)) begin
                n_phase = 12'd0;
            end
            n_any_memo = n_left | n_right;
            n_reverse  = r_reverse ^ i_in_data.command[5];
            n_rv       = n_reverse ? PWM_FULL_LVL : '0;
            n_brake    = r_brake ^ i_in_data.command[4];
            if (n_brake) begin
                if (!n_left) begin
                    n_lr = PWM_FULL_LVL;
                end
                if (!n_right) begin
                    n_rr = PWM_FULL_LVL;
                end
            end else begin
                n_lr = {4'd0, n_rear_base};
                n_rr = {4'd0, n_rear_base};
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_park_base    <= PARK_BASE_RST;
            r_tail_base    <= TAIL_BASE_RST;
            r_low_beam     <= LOW_BEAM_RST;
            r_refresh_ms   <= REFRESH_MS_RST;
            r_blink_period <= BLINK_PERIOD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PARK_BASE:    r_park_base    <= i_cfg_data[7:0];
                CFG_TAIL_BASE:    r_tail_base    <= i_cfg_data[7:0];
                CFG_LOW_BEAM:     r_low_beam     <= i_cfg_data[11:0];
                CFG_REFRESH_MS:   r_refresh_ms   <= i_cfg_data[7:0];
                CFG_BLINK_PERIOD: r_blink_period <= i_cfg_data[10:0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // State update on each accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left          <= 1'b0;
            r_right         <= 1'b0;
            r_any_memo      <= 1'b0;
            r_brake         <= 1'b0;
            r_reverse       <= 1'b0;
            r_level         <= LEVEL_OFF;
            r_phase         <= '0;
            r_refresh_count <= '0;
            r_lf            <= '0;
            r_rf            <= '0;
            r_lr            <= '0;
            r_rr            <= '0;
            r_hl            <= '0;
            r_rv            <= '0;
        end else if (in_accept) begin
            r_left          <= n_left;
            r_right         <= n_right;
            r_any_memo      <= n_any_memo;
            r_brake         <= n_brake;
            r_reverse       <= n_reverse;
            r_level         <= n_level;
            r_phase         <= n_phase;
            r_refresh_count <= n_refresh_count;
            r_lf            <= n_lf;
            r_rf            <= n_rf;
            r_lr            <= n_lr;
            r_rr            <= n_rr;
            r_hl            <= n_hl;
            r_rv            <= n_rv;
        end
    end

    // Result register: load on accept, clear once the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out.left_front    <= n_lf;
            r_out.right_front   <= n_rf;
            r_out.left_rear     <= n_lr;
            r_out.right_rear    <= n_rr;
            r_out.headlight     <= n_hl;
            r_out.reverse_light <= n_rv;
            r_out.status        <= {n_reverse, n_brake, n_level, n_right, n_left};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The memo of any indicator always tracks the two indicator flags
    a_memo_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any_memo == (r_left | r_right))
        else $error("indicator memo out of step with indicator flags");

    // A refresh always leaves the tick count cleared
    a_refresh_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.mode == MODE_TICK && n_refresh) |=> r_refresh_count == 8'd0)
        else $error("refresh did not clear the tick count");

    // A result loaded while the output waits would overwrite it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !in_accept)
        else $error("item accepted while a result was stalled");

    // Status in the result register mirrors the held state
    a_status_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.status == {r_reverse, r_brake, r_level, r_right, r_left})
        else $error("result status differs from held state");

endmodule
